FILE: rtl/core/cdq_pkg.sv
package cdq_pkg;

    localparam int DEPTH_DEFAULT = 8;

    localparam int KIND_W   = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 4;

    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_REAR   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PEEK_FRONT = 3'd4;
    localparam logic [KIND_W-1:0] KIND_PEEK_REAR  = 3'd5;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_DONE  = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

    typedef struct packed {
        logic    valid;
        logic    has_read;
        status_t status;
    } cdq_resp_t;

endpackage

FILE: rtl/core/circular_deque_unit.sv
// Channel   Handshake                 Payload
// -------   ------------------------  ---------------------------------
// command   start, busy (accept when  kind, push_value
//           start high, busy low)
// result    done (one-cycle strobe)   read_value, status, occupancy
//
// One beat can be accepted in every cycle; busy stays low.
// The result appears in the cycle after the command, when the single-port
// slot memory returns its registered read data.
// Reset empties the queue; the slot memory needs no clearing.
// The receiver cannot stall, so results are never held back.
module circular_deque_unit
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    localparam int IDX_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [KIND_W-1:0]        kind,
    input  logic signed [WORD_W-1:0] push_value,
    output logic                     done,
    output logic signed [WORD_W-1:0] read_value,
    output logic [STATUS_W-1:0]      status,
    output logic [OCC_W-1:0]         occupancy
);

    logic                     accept;
    logic                     wr_en;
    logic                     rd_en;
    logic [IDX_W-1:0]         addr;
    logic signed [WORD_W-1:0] rdata;
    cdq_resp_t                resp;
    logic [CNT_W-1:0]         count;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    cdq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .kind   (kind),
        .wr_en  (wr_en),
        .rd_en  (rd_en),
        .addr   (addr),
        .resp   (resp),
        .count  (count)
    );

    cdq_slot_ram #(.DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .wr_en (wr_en),
        .rd_en (rd_en),
        .addr  (addr),
        .wdata (push_value),
        .rdata (rdata)
    );

    assign done       = resp.valid;
    assign read_value = (resp.valid && resp.has_read) ? rdata : '0;
    assign status     = resp.status;

    generate
        if (CNT_W >= OCC_W)
        begin : g_occ_trunc
            assign occupancy = count[OCC_W-1:0];
        end
        else
        begin : g_occ_ext
            assign occupancy = {{(OCC_W - CNT_W){1'b0}}, count};
        end
    endgenerate

endmodule

FILE: rtl/core/cdq_slot_ram.sv
module cdq_slot_ram
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    localparam int IDX_W = $clog2(DEPTH)
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic                     rd_en,
    input  logic [IDX_W-1:0]         addr,
    input  logic signed [WORD_W-1:0] wdata,
    output logic signed [WORD_W-1:0] rdata
);

    logic signed [WORD_W-1:0] mem [DEPTH];
    logic signed [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/cdq_ctrl.sv
module cdq_ctrl
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    localparam int IDX_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic [KIND_W-1:0]        kind,
    output logic                     wr_en,
    output logic                     rd_en,
    output logic [IDX_W-1:0]         addr,
    output cdq_resp_t                resp,
    output logic [CNT_W-1:0]         count
);

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [IDX_W-1:0] front_reg, front_next;
    logic [IDX_W-1:0] rear_reg, rear_next;
    logic [CNT_W-1:0] count_reg, count_next;
    cdq_resp_t        resp_reg, resp_next;

    logic             empty;
    logic             full;
    logic [IDX_W-1:0] front_inc, front_dec, rear_inc, rear_dec;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CNT_FULL);
    assign front_inc = (front_reg == IDX_LAST) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? IDX_LAST : front_reg - 1'b1;
    assign rear_inc  = (rear_reg == IDX_LAST) ? '0 : rear_reg + 1'b1;
    assign rear_dec  = (rear_reg == '0) ? IDX_LAST : rear_reg - 1'b1;

    always_comb
    begin
        front_next = front_reg;
        rear_next  = rear_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        addr       = front_reg;
        resp_next  = '{valid: accept, has_read: 1'b0, status: ST_DONE};
        if (accept)
        begin
            unique case (kind)
                KIND_PUSH_FRONT, KIND_PUSH_REAR:
                begin
                    if (full)
                    begin
                        resp_next.status = ST_FULL;
                    end
                    else if (empty)
                    begin
                        wr_en      = 1'b1;
                        addr       = '0;
                        front_next = '0;
                        rear_next  = '0;
                        count_next = count_reg + 1'b1;
                    end
                    else if (kind == KIND_PUSH_FRONT)
                    begin
                        wr_en      = 1'b1;
                        addr       = front_dec;
                        front_next = front_dec;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        addr       = rear_inc;
                        rear_next  = rear_inc;
                        count_next = count_reg + 1'b1;
                    end
                end
                KIND_POP_FRONT, KIND_POP_REAR, KIND_PEEK_FRONT, KIND_PEEK_REAR:
                begin
                    if (empty)
                    begin
                        resp_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        rd_en              = 1'b1;
                        resp_next.has_read = 1'b1;
                        addr = (kind == KIND_POP_FRONT || kind == KIND_PEEK_FRONT)
                               ? front_reg : rear_reg;
                        if (kind == KIND_POP_FRONT || kind == KIND_POP_REAR)
                        begin
                            count_next = count_reg - 1'b1;
                            if (count_reg == CNT_W'(1))
                            begin
                                front_next = '0;
                                rear_next  = '0;
                            end
                            else if (kind == KIND_POP_FRONT)
                            begin
                                front_next = front_inc;
                            end
                            else
                            begin
                                rear_next = rear_dec;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            rear_reg  <= '0;
            count_reg <= '0;
            resp_reg  <= '0;
        end
        else
        begin
            front_reg <= front_next;
            rear_reg  <= rear_next;
            count_reg <= count_next;
            resp_reg  <= resp_next;
        end
    end

    assign resp  = resp_reg;
    assign count = count_reg;

    // The occupancy never exceeds the store.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("occupancy above depth");

    // An empty queue has both indices parked at slot zero.
    a_empty_parked: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (front_reg == '0 && rear_reg == '0))
        else $error("indices not parked on empty queue");

    // A refused beat leaves the occupancy unchanged.
    a_refused_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (full || empty) && (resp_next.status != ST_DONE))
        |=> (count_reg == $past(count_reg)))
        else $error("refused beat changed occupancy");

    // A memory read is always followed by a read result in the next cycle.
    a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> (resp_reg.valid && resp_reg.has_read))
        else $error("read result missing");

endmodule

FILE: tb/circular_deque_unit_tb.sv
`timescale 1ns / 100ps

module circular_deque_unit_tb;
    import cdq_pkg::*;

    localparam int DEPTH = DEPTH_DEFAULT;

    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        status_t                  st;
        logic [OCC_W-1:0]         occ;
    } deque_result_t;

    typedef struct {
        logic [KIND_W-1:0]        op;
        logic signed [WORD_W-1:0] word;
        bit                       typed;
        deque_result_t            want;
    } directed_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic [KIND_W-1:0]        kind = KIND_PEEK_FRONT;
    logic signed [WORD_W-1:0] push_value = '0;
    logic                     busy;
    logic                     done;
    logic signed [WORD_W-1:0] read_value;
    logic [STATUS_W-1:0]      status;
    logic [OCC_W-1:0]         occupancy;

    bit                       beat_typed = 1'b0;
    deque_result_t            beat_want = '0;

    logic [WORD_W-1:0]        slot_copy [DEPTH];
    int unsigned              head_idx = 0;
    int unsigned              tail_idx = 0;
    int unsigned              fill = 0;
    deque_result_t            pending_results [$];
    int                       mismatches = 0;
    int                       idle_pct = 0;

    circular_deque_unit #(
        .DEPTH(DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .kind(kind),
        .push_value(push_value),
        .done(done),
        .read_value(read_value),
        .status(status),
        .occupancy(occupancy)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("circular_deque_unit_tb: errors");
        $finish;
    end

    function automatic deque_result_t deque_apply(input logic [KIND_W-1:0] op,
                                                  input logic [WORD_W-1:0] word);
        deque_result_t r;
        bit            front_side;
        r = '0;
        r.st = ST_DONE;
        front_side = (op == KIND_POP_FRONT || op == KIND_PEEK_FRONT);
        if (op == KIND_PUSH_FRONT || op == KIND_PUSH_REAR)
        begin
            if (fill >= DEPTH)
            begin
                r.st = ST_FULL;
            end
            else if (fill == 0)
            begin
                head_idx = 0;
                tail_idx = 0;
                slot_copy[0] = word;
                fill = 1;
            end
            else if (op == KIND_PUSH_FRONT)
            begin
                head_idx = (head_idx == 0) ? DEPTH - 1 : head_idx - 1;
                slot_copy[head_idx] = word;
                fill++;
            end
            else
            begin
                tail_idx = (tail_idx == DEPTH - 1) ? 0 : tail_idx + 1;
                slot_copy[tail_idx] = word;
                fill++;
            end
        end
        else if (op >= KIND_POP_FRONT && op <= KIND_PEEK_REAR)
        begin
            if (fill == 0)
            begin
                r.st = ST_EMPTY;
            end
            else
            begin
                r.value = slot_copy[front_side ? head_idx : tail_idx];
                if (op == KIND_POP_FRONT || op == KIND_POP_REAR)
                begin
                    if (fill == 1)
                    begin
                        head_idx = 0;
                        tail_idx = 0;
                    end
                    else if (front_side)
                    begin
                        head_idx = (head_idx == DEPTH - 1) ? 0 : head_idx + 1;
                    end
                    else
                    begin
                        tail_idx = (tail_idx == 0) ? DEPTH - 1 : tail_idx - 1;
                    end
                    fill--;
                end
            end
        end
        r.occ = OCC_W'(fill);
        return r;
    endfunction

    // The expectation is queued before the result is checked, so the order holds
    // whatever the latency of the block.
    always @(posedge clk)
    begin
        deque_result_t predicted;
        deque_result_t got;
        deque_result_t want;
        if (rst_n && start && !busy)
        begin
            predicted = deque_apply(kind, push_value);
            pending_results.push_back(beat_typed ? beat_want : predicted);
        end
        if (rst_n && done)
        begin
            got.value = read_value;
            got.st = status;
            got.occ = occupancy;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: value %0d status %0d occupancy %0d",
                             got.value, got.st, got.occ);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                 want.value, want.st, want.occ,
                                 got.value, got.st, got.occ);
                end
            end
        end
    end

    task automatic send_beat(input logic [KIND_W-1:0] op, input logic [WORD_W-1:0] word,
                             input bit typed, input deque_result_t want);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        kind <= op;
        push_value <= word;
        beat_typed <= typed;
        beat_want <= want;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    task automatic wait_for_results;
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    function automatic directed_row_t mk_row(input logic [KIND_W-1:0] op,
                                             input logic [WORD_W-1:0] word, input bit typed,
                                             input logic [WORD_W-1:0] value,
                                             input status_t st, input int occ);
        directed_row_t row;
        row.op = op;
        row.word = word;
        row.typed = typed;
        row.want.value = value;
        row.want.st = st;
        row.want.occ = OCC_W'(occ);
        return row;
    endfunction

    function automatic logic [KIND_W-1:0] pick_op(input bit filling);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 3)
            return $urandom_range(1) ? KIND_SPARE_HI : KIND_SPARE_LO;
        if (roll < 18)
            return $urandom_range(1) ? KIND_PEEK_REAR : KIND_PEEK_FRONT;
        if ($urandom_range(99) < (filling ? 75 : 25))
            return $urandom_range(1) ? KIND_PUSH_REAR : KIND_PUSH_FRONT;
        return $urandom_range(1) ? KIND_POP_REAR : KIND_POP_FRONT;
    endfunction

    function automatic logic [WORD_W-1:0] pick_word;
        case ($urandom_range(15))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_random(input int beats);
        bit filling;
        filling = 1'b1;
        repeat (beats)
        begin
            if ($urandom_range(19) == 0)
                filling = !filling;
            send_beat(pick_op(filling), pick_word(), 1'b0, '0);
        end
    endtask

    initial
    begin
        directed_row_t rows [25];
        rows[0]  = mk_row(KIND_PEEK_FRONT, 32'h1111_1111, 1'b1, 0, ST_EMPTY, 0);
        rows[1]  = mk_row(KIND_POP_REAR,   32'h2222_2222, 1'b1, 0, ST_EMPTY, 0);
        rows[2]  = mk_row(KIND_PUSH_REAR,  32'h7FFF_FFFF, 1'b1, 0, ST_DONE, 1);
        rows[3]  = mk_row(KIND_PUSH_FRONT, 32'h8000_0000, 1'b1, 0, ST_DONE, 2);
        rows[4]  = mk_row(KIND_PEEK_FRONT, 32'h0, 1'b1, 32'h8000_0000, ST_DONE, 2);
        rows[5]  = mk_row(KIND_PEEK_REAR,  32'h0, 1'b1, 32'h7FFF_FFFF, ST_DONE, 2);
        rows[6]  = mk_row(KIND_SPARE_LO,   32'hDEAD_BEEF, 1'b1, 0, ST_DONE, 2);
        rows[7]  = mk_row(KIND_SPARE_HI,   32'hFFFF_FFFF, 1'b1, 0, ST_DONE, 2);
        rows[8]  = mk_row(KIND_PUSH_FRONT, 32'h0000_0001, 1'b0, 0, ST_DONE, 0);
        rows[9]  = mk_row(KIND_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0, 0, ST_DONE, 0);
        rows[10] = mk_row(KIND_PUSH_FRONT, 32'h5555_5555, 1'b0, 0, ST_DONE, 0);
        rows[11] = mk_row(KIND_PUSH_REAR,  32'hAAAA_AAAA, 1'b0, 0, ST_DONE, 0);
        rows[12] = mk_row(KIND_PUSH_REAR,  32'h0000_0000, 1'b0, 0, ST_DONE, 0);
        rows[13] = mk_row(KIND_PUSH_REAR,  32'h1234_5678, 1'b0, 0, ST_DONE, 0);
        rows[14] = mk_row(KIND_PUSH_REAR,  32'h0BAD_F00D, 1'b1, 0, ST_FULL, DEPTH);
        rows[15] = mk_row(KIND_PUSH_FRONT, 32'hCAFE_0001, 1'b1, 0, ST_FULL, DEPTH);
        rows[16] = mk_row(KIND_POP_REAR,   32'h0, 1'b0, 0, ST_DONE, 0);
        rows[17] = mk_row(KIND_POP_FRONT,  32'h0, 1'b0, 0, ST_DONE, 0);
        rows[18] = mk_row(KIND_POP_FRONT,  32'h0, 1'b0, 0, ST_DONE, 0);
        rows[19] = mk_row(KIND_POP_REAR,   32'h0, 1'b0, 0, ST_DONE, 0);
        rows[20] = mk_row(KIND_POP_FRONT,  32'h0, 1'b0, 0, ST_DONE, 0);
        rows[21] = mk_row(KIND_POP_FRONT,  32'h0, 1'b0, 0, ST_DONE, 0);
        rows[22] = mk_row(KIND_POP_REAR,   32'h0, 1'b0, 0, ST_DONE, 0);
        rows[23] = mk_row(KIND_POP_REAR,   32'h0, 1'b0, 0, ST_DONE, 0);
        rows[24] = mk_row(KIND_POP_FRONT,  32'h0, 1'b1, 0, ST_EMPTY, 0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 20;
        foreach (rows[i])
            send_beat(rows[i].op, rows[i].word, rows[i].typed, rows[i].want);
        run_random(180);
        wait_for_results();

        idle_pct = 61;
        run_random(180);
        wait_for_results();

        idle_pct = 0;
        run_random(180);
        wait_for_results();
        repeat (4) @(posedge clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("circular_deque_unit_tb: clean");
        else
            $display("circular_deque_unit_tb: errors");
        $finish;
    end

endmodule
